@@ sv/assert_macros.svh @@
//------------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U2C_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2c: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define U2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2c: next-cycle property failed");

`endif

@@ sv/u2c_pkg.sv @@
//------------------------------------------------------------------------------
// u2c_pkg
// Shared types, constants and the code point mapping function.
//------------------------------------------------------------------------------
package u2c_pkg;

    localparam int          U2C_QUEUE_DEPTH = 2;
    localparam logic [9:0]  U2C_CAP_RESET   = 10'd63;

    localparam logic [15:0] CP_ASCII_END    = 16'h0080;
    localparam logic [15:0] CP_CYR_FIRST    = 16'h0410;
    localparam logic [15:0] CP_CYR_LAST     = 16'h044F;
    localparam logic [15:0] CP_CYR_OFFSET   = 16'h0350;
    localparam logic [15:0] CP_LATIN1_END   = 16'h0100;
    localparam logic [7:0]  CHAR_UNKNOWN    = 8'h3F;

    // One request's worth of results: up to three characters, the last of
    // which is the terminator when term is set.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] chars;
        logic            term;
    } u2c_pkt_t;

    function automatic logic [7:0] map_code(input logic [15:0] cp);
        logic [7:0] r;
        if (cp < CP_ASCII_END)
        begin
            r = cp[7:0];
        end
        else if (cp >= CP_CYR_FIRST && cp <= CP_CYR_LAST)
        begin
            r = 8'(cp - CP_CYR_OFFSET);
        end
        else
        begin
            case (cp)
                16'h0401: r = 8'hA8;
                16'h0451: r = 8'hB8;
                16'h0402: r = 8'h80;
                16'h0452: r = 8'h90;
                16'h0404: r = 8'hAA;
                16'h0454: r = 8'hBA;
                16'h0406: r = 8'hB2;
                16'h0456: r = 8'hB3;
                16'h0407: r = 8'hAF;
                16'h0457: r = 8'hBF;
                16'h0490: r = 8'hA5;
                16'h0491: r = 8'hB4;
                16'h0408: r = 8'hA3;
                16'h0458: r = 8'hBC;
                16'h0409: r = 8'h8A;
                16'h0459: r = 8'h9A;
                16'h040A: r = 8'h8C;
                16'h045A: r = 8'h9C;
                16'h040B: r = 8'h8E;
                16'h045B: r = 8'h9E;
                16'h040F: r = 8'h8F;
                16'h045F: r = 8'h9F;
                default:  r = (cp < CP_LATIN1_END) ? cp[7:0] : CHAR_UNKNOWN;
            endcase
        end
        return r;
    endfunction

endpackage

@@ sv/u2c_in_if.sv @@
//------------------------------------------------------------------------------
// u2c_in_if
// Source byte channel: valid/ready with one byte per request.
//------------------------------------------------------------------------------
interface u2c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

@@ sv/u2c_out_if.sv @@
//------------------------------------------------------------------------------
// u2c_out_if
// Result channel: valid/ready with one Windows-1251 character per request.
//------------------------------------------------------------------------------
interface u2c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

@@ sv/u2c_queue.sv @@
//------------------------------------------------------------------------------
// u2c_queue
// Small FIFO of result packets between the decoder and the serializer.
//------------------------------------------------------------------------------
module u2c_queue import u2c_pkg::*;
#(
    parameter int DEPTH = U2C_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  u2c_pkt_t wr_pkt,
    input  logic     pop,
    output u2c_pkt_t rd_pkt,
    output logic     empty,
    output logic     full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2c_pkt_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign rd_pkt = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_pkt;
        end
    end

endmodule

@@ sv/u2c_front.sv @@
//------------------------------------------------------------------------------
// u2c_front
// UTF-8 decoder: holds sequence state, counts output, builds result packets.
//------------------------------------------------------------------------------
module u2c_front import u2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [9:0] cfg_data,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_ready,
    input  logic       queue_full,
    output logic       push,
    output u2c_pkt_t   pkt
);

    typedef struct packed {
        logic [9:0]      cnt;
        logic [1:0]      n;
        logic [2:0][7:0] chars;
    } emit_t;

    function automatic emit_t do_emit(input emit_t s, input logic [7:0] c,
                                      input logic [9:0] cap);
        emit_t r;
        r = s;
        if (s.cnt < cap)
        begin
            r.chars[s.n] = c;
            r.n          = s.n + 2'd1;
            r.cnt        = s.cnt + 10'd1;
        end
        return r;
    endfunction

    logic [9:0] cap_reg;
    logic [7:0] lead_reg, lead_next;
    logic [7:0] second_reg, second_next;
    logic [1:0] pend_reg, pend_next;
    logic [9:0] emitted_reg, emitted_next;

    emit_t       st;
    logic        do_start;
    logic        term;
    logic        accept;
    logic [15:0] cp2;
    logic [15:0] cp3;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign cp2      = {5'd0, lead_reg[4:0], in_byte[5:0]};
    assign cp3      = {lead_reg[3:0], second_reg[5:0], in_byte[5:0]};

    always_comb
    begin
        st          = '{cnt: emitted_reg, n: 2'd0, chars: '0};
        lead_next   = lead_reg;
        second_next = second_reg;
        pend_next   = pend_reg;
        do_start    = 1'b0;
        term        = 1'b0;

        if (in_byte == 8'd0)
        begin
            term = 1'b1;
            if (pend_reg != 2'd0)
            begin
                st = do_emit(st, lead_reg, cap_reg);
            end
            if (pend_reg >= 2'd2)
            begin
                st = do_emit(st, second_reg, cap_reg);
            end
            pend_next   = 2'd0;
            lead_next   = 8'd0;
            second_next = 8'd0;
        end
        else if (emitted_reg >= cap_reg)
        begin
            pend_next = 2'd0;
        end
        else if (pend_reg == 2'd0)
        begin
            do_start = 1'b1;
        end
        else if (in_byte[7:6] == 2'b10)
        begin
            if (lead_reg[7:5] == 3'b110)
            begin
                pend_next = 2'd0;
                st        = do_emit(st, map_code(cp2), cap_reg);
            end
            else if (pend_reg == 2'd1)
            begin
                second_next = in_byte;
                pend_next   = 2'd2;
            end
            else
            begin
                pend_next = 2'd0;
                st        = do_emit(st, map_code(cp3), cap_reg);
            end
        end
        else
        begin
            // bad continuation: flush held bytes raw, restart on this byte
            pend_next = 2'd0;
            st        = do_emit(st, lead_reg, cap_reg);
            if (pend_reg >= 2'd2)
            begin
                st = do_emit(st, second_reg, cap_reg);
            end
            do_start = 1'b1;
        end

        if (do_start)
        begin
            if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110)
            begin
                if (st.cnt < cap_reg)
                begin
                    lead_next = in_byte;
                    pend_next = 2'd1;
                end
            end
            else
            begin
                st = do_emit(st, in_byte, cap_reg);
            end
        end

        emitted_next = term ? 10'd0 : st.cnt;

        // terminator slot is already zero in chars
        pkt.count = st.n + {1'b0, term};
        pkt.chars = st.chars;
        pkt.term  = term;
    end

    assign push = accept && (pkt.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= U2C_CAP_RESET;
            lead_reg    <= 8'd0;
            second_reg  <= 8'd0;
            pend_reg    <= 2'd0;
            emitted_reg <= 10'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                lead_reg    <= lead_next;
                second_reg  <= second_next;
                pend_reg    <= pend_next;
                emitted_reg <= emitted_next;
            end
        end
    end

endmodule

@@ sv/u2c_back.sv @@
//------------------------------------------------------------------------------
// u2c_back
// Serializer: walks each packet one character at a time into the output reg.
//------------------------------------------------------------------------------
module u2c_back import u2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  u2c_pkt_t   pkt,
    input  logic       pkt_valid,
    output logic       pop,
    output logic       out_valid,
    output logic [7:0] out_char,
    output logic       out_last,
    input  logic       out_ready
);

    logic [1:0] sub_reg, sub_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       load;
    logic       last_sub;

    assign load      = pkt_valid && (!valid_reg || out_ready);
    assign last_sub  = (sub_reg == pkt.count - 2'd1);
    assign pop       = load && last_sub;
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = last_sub ? 2'd0 : sub_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= pkt.chars[sub_reg];
            last_reg <= pkt.term && last_sub;
        end
    end

endmodule

@@ sv/utf8_to_cp1251_transcoder_core.sv @@
//------------------------------------------------------------------------------
// utf8_to_cp1251_transcoder_core
// UTF-8 to Windows-1251 streaming transcoder, decoder and serializer split by
// a packet queue.
//------------------------------------------------------------------------------
//  channel   dir   payload              handshake
//  byte_ch   in    in_byte[7:0]         valid/ready
//  char_ch   out   out_char[7:0], last  valid/ready
//  cfg       in    cfg_data[9:0]        cfg_we, no read-back
//
//  One byte per cycle; a byte that yields k characters (k up to 3) is sent
//  out one character at a time, so input stalls once the queue fills.
//  A byte's first character is registered in the queue, then in the output register.
//  Async active-low reset clears sequence state, counters and the queue;
//  capacity resets to 63.
//------------------------------------------------------------------------------
module utf8_to_cp1251_transcoder_core import u2c_pkg::*;
#(
    parameter int QUEUE_DEPTH = U2C_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [9:0]   cfg_data,
    u2c_in_if.sink       byte_ch,
    u2c_out_if.source    char_ch
);

    u2c_pkt_t wr_pkt;
    u2c_pkt_t rd_pkt;
    logic     push;
    logic     pop;
    logic     empty;
    logic     full;

    u2c_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (byte_ch.valid),
        .in_byte    (byte_ch.in_byte),
        .in_ready   (byte_ch.ready),
        .queue_full (full),
        .push       (push),
        .pkt        (wr_pkt)
    );

    u2c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_pkt (wr_pkt),
        .pop    (pop),
        .rd_pkt (rd_pkt),
        .empty  (empty),
        .full   (full)
    );

    u2c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (rd_pkt),
        .pkt_valid (!empty),
        .pop       (pop),
        .out_valid (char_ch.valid),
        .out_char  (char_ch.out_char),
        .out_last  (char_ch.out_last),
        .out_ready (char_ch.ready)
    );

endmodule

@@ sv/u2c_checker.sv @@
//------------------------------------------------------------------------------
// u2c_checker
// Port-level checks on the transcoder, bound to the top level.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module u2c_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);

    // stalled result holds
    `U2C_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last))

    // terminator carries a zero character
    `U2C_ASSERT_SAME(a_last_zero, clk, rst_n, out_valid && out_last, out_char == 8'd0)

    // output that stays idle means the queue is drained, so input is open
    `U2C_ASSERT_SAME(a_ready_when_idle, clk, rst_n, !out_valid && !$past(out_valid), in_ready)

    // an input stall while the output is idle is released by ready
    `U2C_ASSERT_NEXT(a_in_hold_seen, clk, rst_n, in_valid && !in_ready && !out_valid, in_ready)

endmodule

bind utf8_to_cp1251_transcoder_core u2c_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_ch.valid),
    .in_ready  (byte_ch.ready),
    .out_valid (char_ch.valid),
    .out_ready (char_ch.ready),
    .out_char  (char_ch.out_char),
    .out_last  (char_ch.out_last)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to Windows-1251 transcoder core. Bytes go
// in over the source channel. A scoreboard class decodes each accepted request
// and queues the characters it should produce. Every character taken from the
// result channel is checked against the oldest one in that queue. A directed
// run is followed by random phases. The phases vary the capacity register and
// the idling on both sides of the block.
//------------------------------------------------------------------------------
module tb_top;
    import u2c_pkg::*;

    localparam int DRAIN_CYCLES   = 10;
    localparam int END_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } cp1251_char_t;

    class u2c_scoreboard;
        logic [9:0]   capacity;
        logic [7:0]   lead;
        logic [7:0]   second;
        logic [1:0]   held;
        logic [9:0]   emitted;
        cp1251_char_t expected_chars[$];
        int           errors;

        function new();
            capacity = U2C_CAP_RESET;
            lead     = '0;
            second   = '0;
            held     = '0;
            emitted  = '0;
            errors   = 0;
        endfunction

        function void set_capacity(logic [9:0] value);
            capacity = value;
        endfunction

        function logic [7:0] to_cp1251(logic [15:0] cp);
            if (cp < 16'h0080)
            begin
                return cp[7:0];
            end
            if (cp >= 16'h0410 && cp <= 16'h044F)
            begin
                return 8'(cp - 16'h0350);
            end
            case (cp)
                16'h0401: return 8'hA8;
                16'h0451: return 8'hB8;
                16'h0402: return 8'h80;
                16'h0452: return 8'h90;
                16'h0404: return 8'hAA;
                16'h0454: return 8'hBA;
                16'h0406: return 8'hB2;
                16'h0456: return 8'hB3;
                16'h0407: return 8'hAF;
                16'h0457: return 8'hBF;
                16'h0490: return 8'hA5;
                16'h0491: return 8'hB4;
                16'h0408: return 8'hA3;
                16'h0458: return 8'hBC;
                16'h0409: return 8'h8A;
                16'h0459: return 8'h9A;
                16'h040A: return 8'h8C;
                16'h045A: return 8'h9C;
                16'h040B: return 8'h8E;
                16'h045B: return 8'h9E;
                16'h040F: return 8'h8F;
                16'h045F: return 8'h9F;
                default:  return (cp < 16'h0100) ? cp[7:0] : CHAR_UNKNOWN;
            endcase
        endfunction

        // Dropped once the string is full.
        function void put_char(logic [7:0] ch);
            if (emitted < capacity)
            begin
                expected_chars.push_back('{ch: ch, last: 1'b0});
                emitted = emitted + 10'd1;
            end
        endfunction

        function void start_sequence(logic [7:0] b);
            if (b < 8'h80)
            begin
                put_char(b);
            end
            else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110)
            begin
                if (emitted < capacity)
                begin
                    lead = b;
                    held = 2'd1;
                end
            end
            else
            begin
                put_char(b);
            end
        endfunction

        function void note_request(logic [7:0] b);
            logic [1:0] was_held;
            if (b == 8'h00)
            begin
                if (held >= 2'd1)
                begin
                    put_char(lead);
                end
                if (held >= 2'd2)
                begin
                    put_char(second);
                end
                expected_chars.push_back('{ch: 8'h00, last: 1'b1});
                held    = '0;
                lead    = '0;
                second  = '0;
                emitted = '0;
                return;
            end
            if (emitted >= capacity)
            begin
                held = '0;
                return;
            end
            if (held == 2'd0)
            begin
                start_sequence(b);
            end
            else if (b[7:6] == 2'b10)
            begin
                if (lead[7:5] == 3'b110)
                begin
                    held = '0;
                    put_char(to_cp1251({5'b0, lead[4:0], b[5:0]}));
                end
                else if (held == 2'd1)
                begin
                    second = b;
                    held   = 2'd2;
                end
                else
                begin
                    held = '0;
                    put_char(to_cp1251({lead[3:0], second[5:0], b[5:0]}));
                end
            end
            else
            begin
                // broken sequence: held bytes go out raw, new byte starts over
                was_held = held;
                held     = '0;
                put_char(lead);
                if (was_held >= 2'd2)
                begin
                    put_char(second);
                end
                if (emitted < capacity)
                begin
                    start_sequence(b);
                end
            end
        endfunction

        function void check_result(logic [7:0] ch, logic last);
            cp1251_char_t exp_c;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected result: out_char=%h out_last=%b", ch, last);
                errors++;
                return;
            end
            exp_c = expected_chars.pop_front();
            if (ch !== exp_c.ch)
            begin
                $error("out_char mismatch: expected %h, actual %h", exp_c.ch, ch);
                errors++;
            end
            if (last !== exp_c.last)
            begin
                $error("out_last mismatch: expected %b, actual %b", exp_c.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [9:0] cfg_data;

    u2c_in_if  byte_if();
    u2c_out_if char_if();

    u2c_scoreboard sb = new();

    int src_idle_pct;
    int sink_idle_pct;
    int bytes_sent;
    int quiet_cycles;

    logic [7:0] directed_bytes [26] = '{
        8'h41,
        8'hD0, 8'h90,
        8'hD1, 8'h8F,
        8'hD2, 8'h91,
        8'hE2, 8'h82, 8'hAC,
        8'hE0, 8'h81, 8'h81,
        8'hE0, 8'h80, 8'h41,
        8'hD0, 8'h41,
        8'hF5,
        8'hFF,
        8'h80,
        8'hC3, 8'h00,
        8'hE1, 8'h81, 8'h00
    };

    utf8_to_cp1251_transcoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .byte_ch  (byte_if),
        .char_ch  (char_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        char_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            char_if.ready = !(sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && char_if.valid && char_if.ready)
        begin
            sb.check_result(char_if.out_char, char_if.out_last);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_if.valid && byte_if.ready) || (char_if.valid && char_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            byte_if.valid = 1'b0;
            @(negedge clk);
        end
        byte_if.valid   = 1'b1;
        byte_if.in_byte = b;
        @(posedge clk);
        while (!byte_if.ready)
        begin
            @(posedge clk);
        end
        sb.note_request(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        byte_if.valid = 1'b0;
        while (sb.expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [9:0] value);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(posedge clk);
        sb.set_capacity(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_sequence();
        int          kind;
        logic [15:0] cp;
        logic [7:0]  b0;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            send_byte(8'h00);
        end
        else if (kind < 30)
        begin
            send_byte(8'($urandom_range(1, 8'h7F)));
        end
        else if (kind < 68)
        begin
            if (kind < 50)
                cp = 16'($urandom_range(16'h0410, 16'h044F));
            else if (kind < 60)
                cp = 16'($urandom_range(16'h0400, 16'h04FF));
            else
                cp = 16'($urandom_range(16'h0080, 16'h00FF));
            send_byte({3'b110, cp[10:6]});
            send_byte({2'b10, cp[5:0]});
        end
        else if (kind < 76)
        begin
            send_byte(8'($urandom_range(8'hC0, 8'hDF)));
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (kind < 84)
        begin
            send_byte(8'($urandom_range(8'hE0, 8'hEF)));
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (kind < 92)
        begin
            b0 = 8'($urandom_range(8'hC0, 8'hEF));
            send_byte(b0);
            if (b0 >= 8'hE0 && $urandom_range(0, 1) == 1)
            begin
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            if ($urandom_range(0, 1) == 1)
                send_byte(8'($urandom_range(1, 8'h7F)));
            else
                send_byte(8'($urandom_range(8'hC0, 8'hFF)));
        end
        else
        begin
            send_byte(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic run_phase(input logic [9:0] cap, input int src_pct, input int sink_pct,
                             input int n_bytes, input bit pause_mid);
        int  start;
        bit  paused;
        wait_drained();
        write_capacity(cap);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < n_bytes)
        begin
            if (pause_mid && !paused && bytes_sent - start >= n_bytes / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            send_sequence();
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = U2C_CAP_RESET;
        byte_if.valid   = 1'b0;
        byte_if.in_byte = 8'h00;
        src_idle_pct    = 0;
        sink_idle_pct   = 0;
        bytes_sent      = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_bytes[i])
        begin
            send_byte(directed_bytes[i]);
        end

        run_phase(10'd1023, 0, 0, 25, 1'b0);
        run_phase(10'd0, 67, 0, 25, 1'b0);
        run_phase(10'd3, 0, 67, 25, 1'b0);
        run_phase(10'd63, 13, 13, 25, 1'b1);
        run_phase(10'd1, 67, 0, 25, 1'b0);
        run_phase(10'($urandom_range(2, 12)), 0, 67, 25, 1'b0);

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.expected_chars.size() != 0)
        begin
            $error("%0d expected characters never arrived", sb.expected_chars.size());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/u2c_pkg.sv
sv/u2c_in_if.sv
sv/u2c_out_if.sv
sv/u2c_queue.sv
sv/u2c_front.sv
sv/u2c_back.sv
sv/utf8_to_cp1251_transcoder_core.sv
sv/u2c_checker.sv
verif/tb_top.sv
